@@ src/assert_macros.svh @@
// Assertion macros shared by the image section table checker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ISC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ISC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISC_ASSERT(lbl, clk, rst, prop, msg)
`define ISC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/isc_pkg.sv @@
// Types and codes for the image section table checker.
// No dependencies; used by the segment cell, the segment chain and the core.
package isc_pkg;

   localparam logic [1:0] ACT_BEGIN   = 2'd0;
   localparam logic [1:0] ACT_SECTION = 2'd1;
   localparam logic [1:0] ACT_XLATE   = 2'd2;

   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_BAD_FORMAT = 2'd1;
   localparam logic [1:0] STS_UNBACKED   = 2'd2;

   localparam logic [2:0] PROT_NOACCESS       = 3'd0;
   localparam logic [2:0] PROT_READONLY       = 3'd1;
   localparam logic [2:0] PROT_WRITECOPY      = 3'd2;
   localparam logic [2:0] PROT_EXECUTE        = 3'd3;
   localparam logic [2:0] PROT_EXEC_READ      = 3'd4;
   localparam logic [2:0] PROT_EXEC_WRITECOPY = 3'd5;

   localparam logic [31:0] SCN_CODE  = 32'h0000_0020;
   localparam logic [31:0] SCN_EXEC  = 32'h2000_0000;
   localparam logic [31:0] SCN_READ  = 32'h4000_0000;
   localparam logic [31:0] SCN_WRITE = 32'h8000_0000;

   localparam logic [1:0] CSR_IMAGE_SIZE  = 2'd0;
   localparam logic [1:0] CSR_HEADER_SIZE = 2'd1;
   localparam logic [1:0] CSR_FILE_SIZE   = 2'd2;

   // lookup token walking the segment chain
   typedef struct packed {
      logic        active;
      logic        found;
      logic [31:0] offset;
   } tok_type;

   // segment store request broadcast to the cells
   typedef struct packed {
      logic        en;
      logic [31:0] start;
      logic [31:0] file_offset;
      logic [31:0] size;
   } seg_wr_type;

endpackage

@@ src/isc_seg_cell.sv @@
// One segment cell: holds a stored segment and matches the passing lookup token.
// Depends on isc_pkg.
module isc_seg_cell #(
   parameter int CNT_W = 5,
   parameter int IDX   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  isc_pkg::seg_wr_type  seg_wr,
   input  logic [CNT_W-1:0]     seg_count,
   input  logic [31:0]          query_rva,
   input  isc_pkg::tok_type     prev_tok,
   output isc_pkg::tok_type     next_tok
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [31:0]      start_ff;
   logic [31:0]      foff_ff;
   logic [31:0]      size_ff;
   isc_pkg::tok_type tok_ff;
   isc_pkg::tok_type tok_in;

   logic        enabled;
   logic [32:0] end_rva;
   logic        hit;
   logic [31:0] hit_offset;

   assign enabled    = MY_IDX < seg_count;
   assign end_rva    = {1'b0, start_ff} + {1'b0, size_ff};
   assign hit        = enabled && (query_rva >= start_ff) && ({1'b0, query_rva} < end_rva);
   assign hit_offset = foff_ff + (query_rva - start_ff);

   always_comb begin
      tok_in = prev_tok;
      if (prev_tok.active && !prev_tok.found && hit) begin
         tok_in.found  = 1'b1;
         tok_in.offset = hit_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (seg_wr.en && (seg_count == MY_IDX)) begin
         start_ff <= seg_wr.start;
         foff_ff  <= seg_wr.file_offset;
         size_ff  <= seg_wr.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign next_tok = tok_ff;

endmodule

@@ src/isc_seg_chain.sv @@
// Row of segment cells; the lookup token moves one cell per cycle.
// Depends on isc_pkg and isc_seg_cell.
module isc_seg_chain #(
   parameter int MAX_SEGMENTS = 16,
   parameter int CNT_W        = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  isc_pkg::seg_wr_type  seg_wr,
   input  logic [CNT_W-1:0]     seg_count,
   input  logic [31:0]          query_rva,
   input  isc_pkg::tok_type     launch_tok,
   output isc_pkg::tok_type     result_tok
);

   isc_pkg::tok_type tok [0:MAX_SEGMENTS];

   assign tok[0] = launch_tok;

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      isc_seg_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .seg_wr    (seg_wr),
         .seg_count (seg_count),
         .query_rva (query_rva),
         .prev_tok  (tok[i]),
         .next_tok  (tok[i+1])
      );
   end

   assign result_tok = tok[MAX_SEGMENTS];

endmodule

@@ src/image_section_table_checker_core.sv @@
// Image section table checker core: section checks and RVA translation.
// One transaction at a time; the next is accepted in the cycle after its result is loaded.
// Translate time is set by the lookup token walking the segment cell chain.
// Synchronous active-high reset clears the control state, the CSR registers and the response valid flag.
// Depends on isc_pkg, isc_seg_chain and assert_macros.svh.
`include "assert_macros.svh"
module image_section_table_checker_core #(
   parameter int PAGE_BYTES   = 4096,
   parameter int MAX_SEGMENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_virtual_address,
   input  logic [31:0] req_virtual_size,
   input  logic [31:0] req_raw_offset,
   input  logic [31:0] req_raw_size,
   input  logic [31:0] req_characteristics,
   input  logic [31:0] req_query_rva,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_protection,
   output logic [31:0] rsp_clipped_raw_size,
   output logic [31:0] rsp_file_offset,
   output logic        rsp_has_code,
   output logic [4:0]  rsp_sections_seen
);

   localparam int          CNT_W     = $clog2(MAX_SEGMENTS + 1);
   localparam logic [32:0] PAGE_MASK = 33'(PAGE_BYTES - 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SEC2  = 3'd2;
   localparam logic [2:0] S_XLATE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   function automatic logic [32:0] page_round(input logic [32:0] v);
      logic [32:0] s;
      s = v + PAGE_MASK;
      return s & ~PAGE_MASK;
   endfunction

   function automatic logic [2:0] prot_of(input logic [31:0] ch);
      logic r;
      logic w;
      logic x;
      r = (ch & isc_pkg::SCN_READ) != 32'd0;
      w = (ch & isc_pkg::SCN_WRITE) != 32'd0;
      x = (ch & isc_pkg::SCN_EXEC) != 32'd0;
      if (x) begin
         return w ? isc_pkg::PROT_EXEC_WRITECOPY :
                (r ? isc_pkg::PROT_EXEC_READ : isc_pkg::PROT_EXECUTE);
      end
      if (w) begin
         return isc_pkg::PROT_WRITECOPY;
      end
      return r ? isc_pkg::PROT_READONLY : isc_pkg::PROT_NOACCESS;
   endfunction

   logic [2:0]  state_ff, state_in;
   logic [1:0]  act_ff, act_in;
   logic [31:0] va_ff, va_in;
   logic [31:0] vsize_ff, vsize_in;
   logic [31:0] roff_ff, roff_in;
   logic [31:0] rsize_ff, rsize_in;
   logic [31:0] ch_ff, ch_in;
   logic [31:0] q_ff, q_in;

   logic [31:0] img_size_ff, img_size_in;
   logic [31:0] hdr_size_ff, hdr_size_in;
   logic [31:0] file_size_ff, file_size_in;

   logic [32:0]      next_free_ff, next_free_in;
   logic [32:0]      rounded_ff, rounded_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             code_seen_ff, code_seen_in;
   logic             fmt_err_ff, fmt_err_in;

   logic [31:0] clipped_ff, clipped_in;
   logic [32:0] sum_ff, sum_in;
   logic        bad_a_ff, bad_a_in;
   logic        roff_ge_ff, roff_ge_in;
   logic [31:0] room_ff, room_in;
   logic [2:0]  prot_ff, prot_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [31:0] res_foff_ff, res_foff_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [2:0]  rsp_prot_ff, rsp_prot_in;
   logic [31:0] rsp_clipped_ff, rsp_clipped_in;
   logic [31:0] rsp_foff_ff, rsp_foff_in;
   logic        rsp_code_ff, rsp_code_in;
   logic [4:0]  rsp_count_ff, rsp_count_in;

   logic [31:0]         eff;
   logic [31:0]         clip_c;
   logic [32:0]         rnd_img;
   logic                bad_a_c;
   logic                bad_b_c;
   logic                out_free;
   logic [31:0]         count_wide;
   isc_pkg::seg_wr_type seg_wr;
   isc_pkg::tok_type    launch_tok;
   isc_pkg::tok_type    result_tok;

   assign eff        = (vsize_ff != 32'd0) ? vsize_ff : rsize_ff;
   assign clip_c     = (rsize_ff > eff) ? eff : rsize_ff;
   assign rnd_img    = page_round({1'b0, img_size_ff});
   assign bad_a_c    = (count_ff >= MAX_CNT) ||
                       (({1'b0, va_ff} & PAGE_MASK) != 33'd0) ||
                       ({1'b0, va_ff} >= rounded_ff) ||
                       (eff == 32'd0) ||
                       ({1'b0, eff} > (rounded_ff - {1'b0, va_ff})) ||
                       ({1'b0, va_ff} < next_free_ff);
   assign bad_b_c    = (clipped_ff != 32'd0) && (roff_ge_ff || (clipped_ff > room_ff));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_wide = 32'(count_ff);

   assign seg_wr.en          = (state_ff == S_SEC2) && !bad_a_ff && !bad_b_c;
   assign seg_wr.start       = va_ff;
   assign seg_wr.file_offset = roff_ff;
   assign seg_wr.size        = clipped_ff;

   assign launch_tok.active = (state_ff == S_EXEC) && (act_ff == isc_pkg::ACT_XLATE) &&
                              !fmt_err_ff;
   assign launch_tok.found  = 1'b0;
   assign launch_tok.offset = 32'd0;

   isc_seg_chain #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .CNT_W        (CNT_W)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .seg_wr     (seg_wr),
      .seg_count  (count_ff),
      .query_rva  (q_ff),
      .launch_tok (launch_tok),
      .result_tok (result_tok)
   );

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      va_in          = va_ff;
      vsize_in       = vsize_ff;
      roff_in        = roff_ff;
      rsize_in       = rsize_ff;
      ch_in          = ch_ff;
      q_in           = q_ff;
      img_size_in    = img_size_ff;
      hdr_size_in    = hdr_size_ff;
      file_size_in   = file_size_ff;
      next_free_in   = next_free_ff;
      rounded_in     = rounded_ff;
      count_in       = count_ff;
      code_seen_in   = code_seen_ff;
      fmt_err_in     = fmt_err_ff;
      clipped_in     = clipped_ff;
      sum_in         = sum_ff;
      bad_a_in       = bad_a_ff;
      roff_ge_in     = roff_ge_ff;
      room_in        = room_ff;
      prot_in        = prot_ff;
      res_status_in  = res_status_ff;
      res_foff_in    = res_foff_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_prot_in    = rsp_prot_ff;
      rsp_clipped_in = rsp_clipped_ff;
      rsp_foff_in    = rsp_foff_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_count_in   = rsp_count_ff;

      if (csr_valid) begin
         case (csr_index)
            isc_pkg::CSR_IMAGE_SIZE:  img_size_in  = csr_wdata;
            isc_pkg::CSR_HEADER_SIZE: hdr_size_in  = csr_wdata;
            isc_pkg::CSR_FILE_SIZE:   file_size_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               va_in    = req_virtual_address;
               vsize_in = req_virtual_size;
               roff_in  = req_raw_offset;
               rsize_in = req_raw_size;
               ch_in    = req_characteristics;
               q_in     = req_query_rva;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            prot_in     = isc_pkg::PROT_NOACCESS;
            clipped_in  = 32'd0;
            res_foff_in = 32'd0;
            state_in    = S_DONE;
            case (act_ff)
               isc_pkg::ACT_BEGIN: begin
                  count_in     = '0;
                  code_seen_in = 1'b0;
                  rounded_in   = rnd_img;
                  fmt_err_in   = (hdr_size_ff > file_size_ff) ||
                                 ({1'b0, hdr_size_ff} > rnd_img) ||
                                 (rnd_img == 33'd0);
                  next_free_in = page_round({1'b0, hdr_size_ff});
                  res_status_in = fmt_err_in ? isc_pkg::STS_BAD_FORMAT : isc_pkg::STS_OK;
               end
               isc_pkg::ACT_SECTION: begin
                  if (fmt_err_ff) begin
                     res_status_in = isc_pkg::STS_BAD_FORMAT;
                  end else begin
                     prot_in    = prot_of(ch_ff);
                     if ((ch_ff & (isc_pkg::SCN_CODE | isc_pkg::SCN_EXEC)) != 32'd0) begin
                        code_seen_in = 1'b1;
                     end
                     clipped_in = clip_c;
                     sum_in     = {1'b0, va_ff} + {1'b0, eff};
                     bad_a_in   = bad_a_c;
                     roff_ge_in = roff_ff >= file_size_ff;
                     room_in    = file_size_ff - roff_ff;
                     state_in   = S_SEC2;
                  end
               end
               isc_pkg::ACT_XLATE: begin
                  if (fmt_err_ff) begin
                     res_status_in = isc_pkg::STS_BAD_FORMAT;
                  end else begin
                     state_in = S_XLATE;
                  end
               end
               default: begin
                  res_status_in = fmt_err_ff ? isc_pkg::STS_BAD_FORMAT : isc_pkg::STS_OK;
               end
            endcase
         end
         S_SEC2: begin
            if (bad_a_ff || bad_b_c) begin
               fmt_err_in    = 1'b1;
               res_status_in = isc_pkg::STS_BAD_FORMAT;
            end else begin
               next_free_in  = page_round(sum_ff);
               count_in      = count_ff + CNT_W'(1);
               res_status_in = isc_pkg::STS_OK;
            end
            state_in = S_DONE;
         end
         S_XLATE: begin
            if (result_tok.active) begin
               if (result_tok.found) begin
                  res_status_in = isc_pkg::STS_OK;
                  res_foff_in   = result_tok.offset;
               end else if (q_ff < hdr_size_ff) begin
                  res_status_in = isc_pkg::STS_OK;
                  res_foff_in   = q_ff;
               end else begin
                  res_status_in = isc_pkg::STS_UNBACKED;
                  res_foff_in   = 32'hFFFF_FFFF;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_prot_in    = prot_ff;
               rsp_clipped_in = clipped_ff;
               rsp_foff_in    = res_foff_ff;
               rsp_code_in    = code_seen_ff;
               rsp_count_in   = count_wide[4:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      va_ff          <= va_in;
      vsize_ff       <= vsize_in;
      roff_ff        <= roff_in;
      rsize_ff       <= rsize_in;
      ch_ff          <= ch_in;
      q_ff           <= q_in;
      clipped_ff     <= clipped_in;
      sum_ff         <= sum_in;
      bad_a_ff       <= bad_a_in;
      roff_ge_ff     <= roff_ge_in;
      room_ff        <= room_in;
      prot_ff        <= prot_in;
      res_status_ff  <= res_status_in;
      res_foff_ff    <= res_foff_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_prot_ff    <= rsp_prot_in;
      rsp_clipped_ff <= rsp_clipped_in;
      rsp_foff_ff    <= rsp_foff_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         img_size_ff  <= 32'd0;
         hdr_size_ff  <= 32'd0;
         file_size_ff <= 32'd0;
         next_free_ff <= 33'd0;
         rounded_ff   <= 33'd0;
         count_ff     <= '0;
         code_seen_ff <= 1'b0;
         fmt_err_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         img_size_ff  <= img_size_in;
         hdr_size_ff  <= hdr_size_in;
         file_size_ff <= file_size_in;
         next_free_ff <= next_free_in;
         rounded_ff   <= rounded_in;
         count_ff     <= count_in;
         code_seen_ff <= code_seen_in;
         fmt_err_ff   <= fmt_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign csr_ready            = 1'b1;
   assign req_stall            = state_ff != S_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_protection       = rsp_prot_ff;
   assign rsp_clipped_raw_size = rsp_clipped_ff;
   assign rsp_file_offset      = rsp_foff_ff;
   assign rsp_has_code         = rsp_code_ff;
   assign rsp_sections_seen    = rsp_count_ff;

   `ISC_ASSERT(a_count_bound, clock, reset, count_ff <= MAX_CNT, "segment count over limit")
   `ISC_ASSERT(a_store_incr, clock, reset, seg_wr.en |=> count_ff == $past(count_ff) + CNT_W'(1), "store did not bump count")
   `ISC_ASSERT(a_xlate_no_err, clock, reset, (state_ff == S_XLATE) |-> !fmt_err_ff, "lookup running after format error")
   `ISC_ASSERT(a_tok_in_xlate, clock, reset, result_tok.active |-> (state_ff == S_XLATE), "lookup token outside translate")

endmodule

@@ bench/tb.sv @@
// Bench for image_section_table_checker_core: a directed table, then random images, sections
// and translations under varying idle, stall and register settings, each result checked against
// its table entry or an in-bench model of the checker. Depends on isc_pkg and the core RTL.
module tb;

   localparam int PAGE = 4096;
   localparam int MAX_SEG = 16;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 2 * (MAX_SEG + 2) + 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 56;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] virtual_address;
      logic [31:0] virtual_size;
      logic [31:0] raw_offset;
      logic [31:0] raw_size;
      logic [31:0] characteristics;
      logic [31:0] query_rva;
   } image_item_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  protection;
      logic [31:0] clipped_raw_size;
      logic [31:0] file_offset;
      logic        has_code;
      logic [4:0]  sections_seen;
   } check_result_t;

   typedef struct packed {
      image_item_t   item;
      logic          typed;
      check_result_t want;
   } table_row_t;

   localparam check_result_t NO_WANT = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = isc_pkg::CSR_IMAGE_SIZE;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = isc_pkg::ACT_BEGIN;
   logic [31:0] req_virtual_address = '0;
   logic [31:0] req_virtual_size = '0;
   logic [31:0] req_raw_offset = '0;
   logic [31:0] req_raw_size = '0;
   logic [31:0] req_characteristics = '0;
   logic [31:0] req_query_rva = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_protection;
   logic [31:0] rsp_clipped_raw_size;
   logic [31:0] rsp_file_offset;
   logic        rsp_has_code;
   logic [4:0]  rsp_sections_seen;

   // checker model state
   logic [31:0] reg_image = '0;
   logic [31:0] reg_header = '0;
   logic [31:0] reg_file = '0;
   logic [63:0] free_rva = '0;
   logic [63:0] image_top = '0;
   logic [31:0] seg_start [MAX_SEG];
   logic [31:0] seg_foff [MAX_SEG];
   logic [31:0] seg_len [MAX_SEG];
   int unsigned seg_count = 0;
   logic        code_flag = 1'b0;
   logic        format_bad = 1'b0;

   check_result_t pending_results[$];
   int            mismatches = 0;
   logic          cur_typed = 1'b0;
   check_result_t cur_want = '0;
   int            sender_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            hold_asked = 0;
   int            hold_served = 0;
   int            hold_left = 0;
   int            quiet_cycles = 0;
   int            items_left = 0;
   logic [31:0]   plan_start[$];
   logic [31:0]   plan_len[$];

   image_section_table_checker_core #(
      .PAGE_BYTES(PAGE),
      .MAX_SEGMENTS(MAX_SEG)
   ) i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] round_page(logic [63:0] v);
      return (v + 64'(PAGE - 1)) & ~64'(PAGE - 1);
   endfunction

   function automatic logic [2:0] page_protection(logic [31:0] ch);
      if ((ch & isc_pkg::SCN_EXEC) != 0) begin
         if ((ch & isc_pkg::SCN_WRITE) != 0) return isc_pkg::PROT_EXEC_WRITECOPY;
         return ((ch & isc_pkg::SCN_READ) != 0) ? isc_pkg::PROT_EXEC_READ :
                                                  isc_pkg::PROT_EXECUTE;
      end
      if ((ch & isc_pkg::SCN_WRITE) != 0) return isc_pkg::PROT_WRITECOPY;
      return ((ch & isc_pkg::SCN_READ) != 0) ? isc_pkg::PROT_READONLY :
                                               isc_pkg::PROT_NOACCESS;
   endfunction

   function automatic check_result_t predict_check(image_item_t it);
      check_result_t r;
      logic [63:0]   va, eff, clip, roff, q, base;
      logic          fail, hit;
      r = '0;
      va = 64'(it.virtual_address);
      roff = 64'(it.raw_offset);
      q = 64'(it.query_rva);
      case (it.action)
         isc_pkg::ACT_BEGIN: begin
            seg_count = 0;
            code_flag = 1'b0;
            image_top = round_page(64'(reg_image));
            format_bad = reg_header > reg_file || 64'(reg_header) > image_top ||
                         image_top == 0;
            free_rva = round_page(64'(reg_header));
            r.status = format_bad ? isc_pkg::STS_BAD_FORMAT : isc_pkg::STS_OK;
         end
         isc_pkg::ACT_SECTION: begin
            if (!format_bad) begin
               eff = (it.virtual_size != 0) ? 64'(it.virtual_size) : 64'(it.raw_size);
               clip = (64'(it.raw_size) > eff) ? eff : 64'(it.raw_size);
               r.protection = page_protection(it.characteristics);
               r.clipped_raw_size = clip[31:0];
               if ((it.characteristics & (isc_pkg::SCN_CODE | isc_pkg::SCN_EXEC)) != 0)
                  code_flag = 1'b1;
               fail = seg_count >= MAX_SEG || (va & 64'(PAGE - 1)) != 0 ||
                      va >= image_top || eff == 0 || eff > image_top - va || va < free_rva;
               if (!fail && clip != 0 &&
                   (roff >= 64'(reg_file) || clip > 64'(reg_file) - roff))
                  fail = 1'b1;
               if (fail) begin
                  format_bad = 1'b1;
               end else begin
                  free_rva = round_page(va + eff);
                  seg_start[seg_count] = it.virtual_address;
                  seg_foff[seg_count] = it.raw_offset;
                  seg_len[seg_count] = clip[31:0];
                  seg_count++;
               end
            end
            r.status = format_bad ? isc_pkg::STS_BAD_FORMAT : isc_pkg::STS_OK;
         end
         isc_pkg::ACT_XLATE: begin
            if (format_bad) begin
               r.status = isc_pkg::STS_BAD_FORMAT;
            end else begin
               hit = 1'b0;
               for (int i = 0; i < MAX_SEG; i++) begin
                  base = 64'(seg_start[i]);
                  if (!hit && i < seg_count && q >= base && q < base + 64'(seg_len[i])) begin
                     r.file_offset = 32'(64'(seg_foff[i]) + q - base);
                     hit = 1'b1;
                  end
               end
               if (!hit) begin
                  if (q < 64'(reg_header)) begin
                     r.file_offset = it.query_rva;
                  end else begin
                     r.status = isc_pkg::STS_UNBACKED;
                     r.file_offset = '1;
                  end
               end
            end
         end
         default: r.status = format_bad ? isc_pkg::STS_BAD_FORMAT : isc_pkg::STS_OK;
      endcase
      r.has_code = code_flag;
      r.sections_seen = 5'(seg_count);
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      check_result_t got, exp_r;
      image_item_t   seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_protection, rsp_clipped_raw_size, rsp_file_offset,
                   rsp_has_code, rsp_sections_seen};
            if (pending_results.size() == 0) begin
               $error("unexpected result transaction, status %0d", got.status);
               mismatches++;
            end else begin
               exp_r = pending_results.pop_front();
               if (got.status != exp_r.status) begin
                  $error("status: expected %0d, got %0d", exp_r.status, got.status);
                  mismatches++;
               end
               if (got.protection != exp_r.protection) begin
                  $error("protection: expected %0d, got %0d", exp_r.protection,
                         got.protection);
                  mismatches++;
               end
               if (got.clipped_raw_size != exp_r.clipped_raw_size) begin
                  $error("clipped_raw_size: expected %h, got %h", exp_r.clipped_raw_size,
                         got.clipped_raw_size);
                  mismatches++;
               end
               if (got.file_offset != exp_r.file_offset) begin
                  $error("file_offset: expected %h, got %h", exp_r.file_offset,
                         got.file_offset);
                  mismatches++;
               end
               if (got.has_code != exp_r.has_code) begin
                  $error("has_code: expected %0d, got %0d", exp_r.has_code, got.has_code);
                  mismatches++;
               end
               if (got.sections_seen != exp_r.sections_seen) begin
                  $error("sections_seen: expected %0d, got %0d", exp_r.sections_seen,
                         got.sections_seen);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               isc_pkg::CSR_IMAGE_SIZE:  reg_image = csr_wdata;
               isc_pkg::CSR_HEADER_SIZE: reg_header = csr_wdata;
               isc_pkg::CSR_FILE_SIZE:   reg_file = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            seen = {req_action, req_virtual_address, req_virtual_size, req_raw_offset,
                    req_raw_size, req_characteristics, req_query_rva};
            exp_r = predict_check(seen);
            pending_results.push_back(cur_typed ? cur_want : exp_r);
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic image_item_t mk_item(logic [1:0] act, logic [31:0] va, vs, roff, rs,
                                           ch, q);
      return {act, va, vs, roff, rs, ch, q};
   endfunction

   function automatic check_result_t mk_want(logic [1:0] st, logic [2:0] prot,
                                             logic [31:0] clip, foff, logic code,
                                             logic [4:0] cnt);
      return {st, prot, clip, foff, code, cnt};
   endfunction

   task automatic offer_item(image_item_t it, logic typed, check_result_t want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_action, req_virtual_address, req_virtual_size, req_raw_offset, req_raw_size,
       req_characteristics, req_query_rva} <= it;
      cur_typed <= typed;
      cur_want <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_left--;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic program_regs(logic [31:0] img, hdr, fsz);
      req_valid <= 1'b0;
      drain_results();
      repeat (4) @(posedge clock);
      write_reg(isc_pkg::CSR_IMAGE_SIZE, img);
      write_reg(isc_pkg::CSR_HEADER_SIZE, hdr);
      write_reg(isc_pkg::CSR_FILE_SIZE, fsz);
      csr_valid <= 1'b0;
   endtask

   task automatic offer_lookup;
      logic [31:0] q;
      int          k;
      k = $urandom_range(0, 9);
      if (plan_start.size() != 0 && k < 6) begin
         k = $urandom_range(0, plan_start.size() - 1);
         q = plan_start[k] + $urandom_range(0, plan_len[k]);
      end else if (k < 8) begin
         q = $urandom_range(0, 1) ? reg_header : $urandom_range(0, reg_header);
      end else begin
         q = $urandom();
      end
      offer_item(mk_item(isc_pkg::ACT_XLATE, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), q), 1'b0, NO_WANT);
   endtask

   // one begin, a run of mostly well-formed sections, lookups in between and after
   task automatic offer_image;
      logic [63:0] cursor, fcur, va, eff, rs, clip;
      logic [31:0] ch;
      int          nsec;
      offer_item(mk_item(isc_pkg::ACT_BEGIN, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom()), 1'b0, NO_WANT);
      plan_start.delete();
      plan_len.delete();
      cursor = round_page(64'(reg_header));
      fcur = 64'(reg_header);
      nsec = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
      for (int n = 0; n < nsec; n++) begin
         va = cursor + 64'(PAGE * $urandom_range(0, 1));
         eff = 64'($urandom_range(1, 2 * PAGE));
         case ($urandom_range(0, 19))
            0: va = va + 64'($urandom_range(1, PAGE - 1));
            1: va = (va >= 64'(PAGE)) ? va - 64'(PAGE) : va;
            default: ;
         endcase
         case ($urandom_range(0, 4))
            0: rs = 64'(0);
            1: rs = 64'($urandom_range(0, 32'(eff)));
            2: rs = eff + 64'($urandom_range(1, PAGE));
            default: rs = eff;
         endcase
         ch = $urandom() & ($urandom_range(0, 1) ? 32'hFFFF_FFFF :
                            (isc_pkg::SCN_CODE | isc_pkg::SCN_EXEC | isc_pkg::SCN_READ |
                             isc_pkg::SCN_WRITE));
         clip = (rs > eff) ? eff : rs;
         if ($urandom_range(0, 3) == 0) begin
            offer_item(mk_item(isc_pkg::ACT_SECTION, va[31:0], 32'h0, fcur[31:0], eff[31:0],
                               ch, $urandom()), 1'b0, NO_WANT);
            clip = eff;
         end else begin
            offer_item(mk_item(isc_pkg::ACT_SECTION, va[31:0], eff[31:0], fcur[31:0],
                               rs[31:0], ch, $urandom()), 1'b0, NO_WANT);
         end
         plan_start.push_back(va[31:0]);
         plan_len.push_back(clip[31:0]);
         cursor = round_page(va + eff);
         fcur = fcur + clip + 64'($urandom_range(0, 256));
         if ($urandom_range(0, 3) == 0) offer_lookup();
      end
      repeat ($urandom_range(2, 8)) offer_lookup();
   endtask

   task automatic offer_noise;
      image_item_t it;
      it = {2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom()};
      if ($urandom_range(0, 1) == 0) it.virtual_address = it.virtual_address & ~32'(PAGE - 1);
      if ($urandom_range(0, 3) == 0) it.virtual_size = '0;
      if ($urandom_range(0, 3) == 0) it.raw_size = '0;
      offer_item(it, 1'b0, NO_WANT);
   endtask

   initial begin : stimulus
      table_row_t  rows[$];
      logic [31:0] img, hdr, fsz;
      logic        held;
      // image 0xF001 rounds to 0x10000, header 0x400, file 0x9000
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'h1000, 32'h1000, 32'h400, 32'h200,
                              isc_pkg::SCN_READ, 0), 1'b1,
                      mk_want(isc_pkg::STS_BAD_FORMAT, isc_pkg::PROT_READONLY, 32'h200, 0,
                              1'b0, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, 32'h10), 1'b1,
                      mk_want(isc_pkg::STS_BAD_FORMAT, isc_pkg::PROT_NOACCESS, 0, 0,
                              1'b0, 5'd0)});
      rows.push_back({mk_item(ACT_UNUSED, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_want(isc_pkg::STS_BAD_FORMAT, isc_pkg::PROT_NOACCESS, 0, 0,
                              1'b0, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 0, 1'b0, 5'd0)});
      rows.push_back({mk_item(ACT_UNUSED, '1, '1, '1, '1, '1, '1), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 0, 1'b0, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, 32'h3FF), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 32'h3FF,
                              1'b0, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, 32'h400), 1'b1,
                      mk_want(isc_pkg::STS_UNBACKED, isc_pkg::PROT_NOACCESS, 0, '1,
                              1'b0, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'h1000, 32'h1800, 32'h400, 32'h2000,
                              isc_pkg::SCN_CODE | isc_pkg::SCN_EXEC | isc_pkg::SCN_READ, 0),
                      1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_EXEC_READ, 32'h1800, 0,
                              1'b1, 5'd1)});
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'h3000, 0, 32'h1C00, 32'h1000,
                              isc_pkg::SCN_WRITE, 0), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_WRITECOPY, 32'h1000, 0,
                              1'b1, 5'd2)});
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'h4000, 32'h2000, 0, 0, 0, 0), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 0, 1'b1, 5'd3)});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, 32'h1000), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 32'h400,
                              1'b1, 5'd3)});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, 32'h27FF), 1'b0, NO_WANT});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, 32'h2800), 1'b1,
                      mk_want(isc_pkg::STS_UNBACKED, isc_pkg::PROT_NOACCESS, 0, '1,
                              1'b1, 5'd3)});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, 32'h3FFF), 1'b0, NO_WANT});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, '1), 1'b1,
                      mk_want(isc_pkg::STS_UNBACKED, isc_pkg::PROT_NOACCESS, 0, '1,
                              1'b1, 5'd3)});
      // misaligned start
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'h6010, 32'h100, 0, 32'h80,
                              isc_pkg::SCN_READ | isc_pkg::SCN_EXEC, 0), 1'b1,
                      mk_want(isc_pkg::STS_BAD_FORMAT, isc_pkg::PROT_EXEC_READ, 32'h80, 0,
                              1'b1, 5'd3)});
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'h6000, 32'h1000, 0, 0,
                              isc_pkg::SCN_CODE, 0), 1'b1,
                      mk_want(isc_pkg::STS_BAD_FORMAT, isc_pkg::PROT_NOACCESS, 0, 0,
                              1'b1, 5'd3)});
      rows.push_back({mk_item(isc_pkg::ACT_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 0, 1'b0, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'h1000, '1, '1, '1, '1, '1), 1'b1,
                      mk_want(isc_pkg::STS_BAD_FORMAT, isc_pkg::PROT_EXEC_WRITECOPY, '1, 0,
                              1'b1, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 0, 1'b0, 5'd0)});
      // zero size, and below the header
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 0, 0, 0, 0,
                              isc_pkg::SCN_READ | isc_pkg::SCN_WRITE, 0), 1'b1,
                      mk_want(isc_pkg::STS_BAD_FORMAT, isc_pkg::PROT_WRITECOPY, 0, 0,
                              1'b0, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 0, 1'b0, 5'd0)});
      // raw bytes past the end of the file
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'h1000, 32'h1000, 32'h8C00, 32'h800,
                              isc_pkg::SCN_EXEC, 0), 1'b1,
                      mk_want(isc_pkg::STS_BAD_FORMAT, isc_pkg::PROT_EXECUTE, 32'h800, 0,
                              1'b1, 5'd0)});
      rows.push_back({mk_item(isc_pkg::ACT_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 0, 1'b0, 5'd0)});
      // last page of the image, no raw bytes
      rows.push_back({mk_item(isc_pkg::ACT_SECTION, 32'hF000, 32'h1000, 32'h9000, 0, 0, 0),
                      1'b1,
                      mk_want(isc_pkg::STS_OK, isc_pkg::PROT_NOACCESS, 0, 0, 1'b0, 5'd1)});
      rows.push_back({mk_item(isc_pkg::ACT_XLATE, 0, 0, 0, 0, 0, 32'hF000), 1'b1,
                      mk_want(isc_pkg::STS_UNBACKED, isc_pkg::PROT_NOACCESS, 0, '1,
                              1'b0, 5'd1)});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      program_regs(32'h0000_F001, 32'h0000_0400, 32'h0000_9000);
      foreach (rows[i]) offer_item(rows[i].item, rows[i].typed, rows[i].want);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: {img, hdr, fsz} = '0;
            2: {img, hdr, fsz} = '1;
            3: {img, hdr, fsz} = {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
            5: {img, hdr, fsz} = {32'h0004_0000, 32'h0000_3000, 32'h0000_2000};
            default: begin
               img = $urandom_range(32'h8000, 32'h20_0000);
               hdr = $urandom_range(0, 32'h1000);
               fsz = $urandom_range(32'h1_0000, 32'h40_0000);
            end
         endcase
         program_regs(img, hdr, fsz);
         case (p % 4)
            0: begin sender_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin sender_idle_pct <= 55; recv_stall_pct <= 0;  end
            2: begin sender_idle_pct <= 0;  recv_stall_pct <= 55; end
            default: begin sender_idle_pct <= 17; recv_stall_pct <= 17; end
         endcase
         items_left = PHASE_ITEMS;
         held = 1'b0;
         while (items_left > 0) begin
            if (!held && items_left < PHASE_ITEMS / 2) begin
               held = 1'b1;
               if (p == 4) hold_asked <= hold_asked + 1;
               if (p == 6) drain_results();
            end
            if ($urandom_range(0, 99) < 80) offer_image();
            else offer_noise();
         end
      end

      req_valid <= 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
